// ===== hdl/u8u16_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and lead byte decode for the UTF-8 to UTF-16 unit.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int CFG_INDEX_W         = 1;
  localparam int CFG_DATA_W          = 16;
  localparam int UNIT_W              = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_SLASH_CONVERT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY      = 1'b1;

  localparam logic [7:0]        ASCII_BACKSLASH = 8'h5C;
  localparam logic [7:0]        ASCII_SLASH     = 8'h2F;
  localparam logic [5:0]        CONT_DATA_MASK  = 6'h3F;
  localparam logic [UNIT_W-1:0] INDEX_MAX       = 16'hFFFF;
  localparam logic [UNIT_W-1:0] CAPACITY_RESET  = 16'hFFFF;

  typedef struct packed {
    logic              valid;
    logic [UNIT_W-1:0] code;
  } code_beat_t;

  typedef struct packed {
    logic [2:0] len_m1;
    logic [7:0] mask;
  } lead_class_t;

  function automatic lead_class_t lead_class(input logic [7:0] b);
    lead_class_t r;
    priority if ((b & 8'h80) == 8'h00) r = '{3'd0, 8'h7F};
    else if ((b & 8'hE0) == 8'hC0)     r = '{3'd1, 8'h1F};
    else if ((b & 8'hF0) == 8'hE0)     r = '{3'd2, 8'h0F};
    else if ((b & 8'hF8) == 8'hF0)     r = '{3'd3, 8'h07};
    else if ((b & 8'hFC) == 8'hF8)     r = '{3'd4, 8'h03};
    else if ((b & 8'hFE) == 8'hFC)     r = '{3'd5, 8'h01};
    else                               r = '{3'd0, 8'h00};
    return r;
  endfunction

endpackage

// ===== hdl/utf8_to_utf16_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit
// A character's result passes through the queue and then the result register.
// Throughput: one byte per cycle while full is low, set by the front accumulate step.
// Reset (rst, synchronous): clears decode state, index, queue; registers
// return to slash_convert 0, capacity 65535. No clearing pass.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_unit
  import u8u16_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             in_byte,
  output logic                   empty,
  input  logic                   pop,
  output logic [UNIT_W-1:0]      code_unit,
  output logic [UNIT_W-1:0]      unit_index,
  output logic                   stored,
  output logic                   end_of_string
);

  logic              slash_convert;
  logic [UNIT_W-1:0] capacity;
  code_beat_t        front_beat;
  logic              queue_full;
  logic              q_valid;
  logic              q_rd;
  logic [UNIT_W-1:0] q_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      slash_convert <= 1'b0;
      capacity      <= CAPACITY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SLASH_CONVERT: slash_convert <= cfg_data[0];
        CFG_CAPACITY:      capacity      <= cfg_data[UNIT_W-1:0];
        default:           ;
      endcase
    end
  end

  u8u16_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .in_byte       (in_byte),
    .slash_convert (slash_convert),
    .queue_full    (queue_full),
    .full          (full),
    .beat          (front_beat)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_beat (front_beat),
    .full    (queue_full),
    .valid   (q_valid),
    .rd      (q_rd),
    .rd_code (q_code)
  );

  u8u16_back u_back (
    .clk           (clk),
    .rst           (rst),
    .capacity      (capacity),
    .q_valid       (q_valid),
    .q_code        (q_code),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .code_unit     (code_unit),
    .unit_index    (unit_index),
    .stored        (stored),
    .end_of_string (end_of_string)
  );

endmodule

// ===== hdl/u8u16_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_front
// Takes source bytes, classifies lead bytes and gathers code bits.
// ----------------------------------------------------------------------------
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       slash_convert,
  input  logic       queue_full,
  output logic       full,
  output code_beat_t beat
);

  logic [UNIT_W-1:0] accumulator;
  logic [UNIT_W-1:0] accumulator_next;
  logic [2:0]        bytes_left;
  logic [2:0]        bytes_left_next;
  logic              accept;
  lead_class_t       lc;
  logic [7:0]        ascii;

  assign full   = queue_full;
  assign accept = push && !queue_full;
  assign lc     = lead_class(in_byte);
  assign ascii  = (slash_convert && in_byte == ASCII_BACKSLASH) ? ASCII_SLASH : in_byte;

  always_comb begin
    if (bytes_left != 3'd0) begin
      accumulator_next = {accumulator[UNIT_W-7:0], in_byte[5:0] & CONT_DATA_MASK};
      bytes_left_next  = bytes_left - 3'd1;
    end else begin
      if (!in_byte[7]) begin
        accumulator_next = {8'h00, ascii};
      end else begin
        accumulator_next = {8'h00, in_byte & lc.mask};
      end
      bytes_left_next = lc.len_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      bytes_left  <= '0;
    end else if (accept) begin
      accumulator <= accumulator_next;
      bytes_left  <= bytes_left_next;
    end
  end

  assign beat.valid = accept && (bytes_left_next == 3'd0);
  assign beat.code  = accumulator_next;

endmodule

// ===== hdl/u8u16_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_queue
// Short queue of finished code units between the front and back parts.
// ----------------------------------------------------------------------------
module u8u16_queue
  import u8u16_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  code_beat_t        wr_beat,
  output logic              full,
  output logic              valid,
  input  logic              rd,
  output logic [UNIT_W-1:0] rd_code
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [UNIT_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == FULL_CNT);
  assign valid   = (count != '0);
  assign do_wr   = wr_beat.valid && !full;
  assign do_rd   = rd && valid;
  assign rd_code = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_beat.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/u8u16_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_back
// Numbers code units, flags destination fit and holds the result register.
// ----------------------------------------------------------------------------
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [UNIT_W-1:0] capacity,
  input  logic              q_valid,
  input  logic [UNIT_W-1:0] q_code,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output logic [UNIT_W-1:0] code_unit,
  output logic [UNIT_W-1:0] unit_index,
  output logic              stored,
  output logic              end_of_string
);

  logic [UNIT_W-1:0] write_index;
  logic [UNIT_W-1:0] write_index_next;
  logic              out_valid;
  logic              code_zero;

  assign empty     = !out_valid;
  assign q_rd      = q_valid && (!out_valid || pop);
  assign code_zero = (q_code == '0);

  always_comb begin
    priority if (code_zero)           write_index_next = '0;
    else if (write_index != INDEX_MAX) write_index_next = write_index + UNIT_W'(1);
    else                               write_index_next = write_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (q_rd) begin
        write_index <= write_index_next;
        out_valid   <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      code_unit     <= q_code;
      unit_index    <= write_index;
      stored        <= (write_index < capacity);
      end_of_string <= code_zero;
    end
  end

endmodule

// ===== hdl/u8u16_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks on result numbering, fit flag and end of string.
// ----------------------------------------------------------------------------
module u8u16_checker
  import u8u16_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   cfg_write,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data,
  input logic                   empty,
  input logic                   pop,
  input logic [UNIT_W-1:0]      code_unit,
  input logic [UNIT_W-1:0]      unit_index,
  input logic                   stored,
  input logic                   end_of_string
);

  logic [UNIT_W-1:0] cap_shadow;
  logic [UNIT_W-1:0] last_index;
  logic [UNIT_W-1:0] expect_index;
  logic              last_eos;
  logic              seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_shadow <= CAPACITY_RESET;
      seen       <= 1'b0;
      last_eos   <= 1'b0;
      last_index <= '0;
    end else begin
      if (cfg_write && cfg_index == CFG_CAPACITY) begin
        cap_shadow <= cfg_data[UNIT_W-1:0];
      end
      if (pop && !empty) begin
        seen       <= 1'b1;
        last_eos   <= end_of_string;
        last_index <= unit_index;
      end
    end
  end

  assign expect_index = !seen || last_eos ? '0 :
                        (last_index == INDEX_MAX) ? INDEX_MAX : last_index + UNIT_W'(1);

  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result visible right after reset");

  a_eos_matches_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (end_of_string == (code_unit == '0)))
    else $error("end_of_string does not match code unit");

  a_stored_fit: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (stored == (unit_index < cap_shadow)))
    else $error("stored flag does not match capacity");

  a_index_sequence: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (unit_index == expect_index))
    else $error("unit index out of sequence");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(code_unit) && $stable(unit_index)))
    else $error("stalled result beat changed");

endmodule

bind utf8_to_utf16_decoder_unit u8u16_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_write     (cfg_write),
  .cfg_index     (cfg_index),
  .cfg_data      (cfg_data),
  .empty         (empty),
  .pop           (pop),
  .code_unit     (code_unit),
  .unit_index    (unit_index),
  .stored        (stored),
  .end_of_string (end_of_string)
);

// ===== test/utf8_to_utf16_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit_tb
// Feeds UTF-8 byte strings through the decoder, runs a directed list of lead
// classes, invalid leads and register settings, then runs random strings
// under several idle/stall mixes. Every popped code unit is compared against
// the directed row's expected unit or, for other bytes, a behavioral decoder.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_unit_tb;
  import u8u16_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_BYTES    = 90;

  typedef struct packed {
    logic [UNIT_W-1:0] code;
    logic [UNIT_W-1:0] idx;
    logic              stored;
    logic              eos;
  } unit_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [7:0]        b;
    bit                typed;
    unit_t             want;
    logic              slash;
    logic [UNIT_W-1:0] cap;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [7:0]             in_byte = 8'h00;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [UNIT_W-1:0]      code_unit;
  logic [UNIT_W-1:0]      unit_index;
  logic                   stored;
  logic                   end_of_string;

  // decoder model state and register copies
  logic [UNIT_W-1:0] dec_acc = '0;
  logic [2:0]        dec_left = '0;
  logic [UNIT_W-1:0] dec_idx = '0;
  logic              dec_slash = 1'b0;
  logic [UNIT_W-1:0] dec_cap = CAPACITY_RESET;

  unit_t       pending_units[$];
  row_t        dir_rows[$];
  int          row_tag = -1;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent_bytes = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;

  utf8_to_utf16_decoder_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .empty        (empty),
    .pop          (pop),
    .code_unit    (code_unit),
    .unit_index   (unit_index),
    .stored       (stored),
    .end_of_string(end_of_string)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit decode_step(input logic [7:0] b, output unit_t u);
    logic [7:0] mask;
    logic [2:0] extra;
    logic [7:0] ch;
    u = '0;
    if (dec_left != 3'd0) begin
      dec_acc  = {dec_acc[UNIT_W-7:0], b[5:0] & CONT_DATA_MASK};
      dec_left = dec_left - 3'd1;
    end else begin
      casez (b)
        8'b0???????: begin extra = 3'd0; mask = 8'h7F; end
        8'b110?????: begin extra = 3'd1; mask = 8'h1F; end
        8'b1110????: begin extra = 3'd2; mask = 8'h0F; end
        8'b11110???: begin extra = 3'd3; mask = 8'h07; end
        8'b111110??: begin extra = 3'd4; mask = 8'h03; end
        8'b1111110?: begin extra = 3'd5; mask = 8'h01; end
        default:     begin extra = 3'd0; mask = 8'h00; end
      endcase
      ch = b;
      if (!b[7] && dec_slash && b == ASCII_BACKSLASH) ch = ASCII_SLASH;
      dec_acc  = {8'h00, ch & mask};
      dec_left = extra;
    end
    if (dec_left != 3'd0) return 1'b0;
    u.code   = dec_acc;
    u.idx    = dec_idx;
    u.stored = (dec_idx < dec_cap);
    u.eos    = (dec_acc == '0);
    if (dec_acc == '0) dec_idx = '0;
    else if (dec_idx != INDEX_MAX) dec_idx = dec_idx + 1'b1;
    return 1'b1;
  endfunction

  function automatic void byte_row(input logic [7:0] b);
    row_t r;
    r = '{ROW_BYTE, b, 1'b0, unit_t'('0), 1'b0, '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void unit_row(input logic [7:0] b, input logic [UNIT_W-1:0] code,
                                   input logic [UNIT_W-1:0] idx, input logic st,
                                   input logic eos);
    row_t r;
    r = '{ROW_BYTE, b, 1'b1, unit_t'({code, idx, st, eos}), 1'b0, '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void cfg_row(input logic slash, input logic [UNIT_W-1:0] cap);
    row_t r;
    r = '{ROW_CFG, 8'h00, 1'b0, unit_t'('0), slash, cap};
    dir_rows.push_back(r);
  endfunction

  task automatic report_mismatch(input string name, input logic [UNIT_W-1:0] got,
                                 input logic [UNIT_W-1:0] want);
    $display("ERROR %0t: %s got %h expected %h", $time, name, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    unit_t want;
    unit_t next_u;
    bit    busy;
    bit    has_unit;
    if (!rst) begin
      busy = 1'b0;
      if (pop && !empty) begin
        busy = 1'b1;
        if (pending_units.size() == 0) begin
          report_mismatch("unexpected code_unit", code_unit, '0);
        end else begin
          want = pending_units.pop_front();
          if (code_unit !== want.code) report_mismatch("code_unit", code_unit, want.code);
          if (unit_index !== want.idx) report_mismatch("unit_index", unit_index, want.idx);
          if (stored !== want.stored) report_mismatch("stored", stored, want.stored);
          if (end_of_string !== want.eos)
            report_mismatch("end_of_string", end_of_string, want.eos);
        end
      end
      if (push && !full) begin
        busy = 1'b1;
        has_unit = decode_step(in_byte, next_u);
        if (row_tag >= 0 && dir_rows[row_tag].typed) pending_units.push_back(dir_rows[row_tag].want);
        else if (has_unit) pending_units.push_back(next_u);
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input int tag);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    row_tag <= tag;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_char();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  r;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    r    = 8'($urandom_range(0, 255));
    if (pick < 10) begin
      send_byte(r, -1);
    end else if (pick < 18) begin
      send_byte(8'h00, -1);
    end else if (pick < 22) begin
      send_byte(ASCII_BACKSLASH, -1);
    end else begin
      len = (pick < 55) ? 1 : $urandom_range(2, 6);
      case (len)
        1:       c = {1'b0, r[6:0]};
        2:       c = {3'b110, r[4:0]};
        3:       c = {4'b1110, r[3:0]};
        4:       c = {5'b11110, r[2:0]};
        5:       c = {6'b111110, r[1:0]};
        default: c = {7'b1111110, r[0]};
      endcase
      send_byte(c, -1);
      repeat (len - 1) begin
        if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
        else c = {2'b10, 6'($urandom_range(0, 63))};
        send_byte(c, -1);
      end
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_units.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic slash, input logic [UNIT_W-1:0] cap);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SLASH_CONVERT;
    cfg_data  <= CFG_DATA_W'(slash);
    @(posedge clk);
    cfg_index <= CFG_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_write <= 1'b0;
    dec_slash = slash;
    dec_cap   = cap;
  endtask

  initial begin
    int unsigned start;
    bit          held;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: slash off, capacity 65535
    unit_row(8'h7F, 16'h007F, 16'd0, 1'b1, 1'b0);
    unit_row(8'h5C, 16'h005C, 16'd1, 1'b1, 1'b0);
    byte_row(8'hC3); byte_row(8'hA9);
    byte_row(8'hE2); byte_row(8'h82); byte_row(8'hAC);
    byte_row(8'hF0); byte_row(8'h9F); byte_row(8'h98); byte_row(8'h80);
    // six-byte lead, continuations taken whatever their value
    byte_row(8'hFD); byte_row(8'h00); byte_row(8'hFF);
    byte_row(8'h3F); byte_row(8'hC0); byte_row(8'h7F);
    unit_row(8'h80, 16'h0000, 16'd6, 1'b1, 1'b1);
    cfg_row(1'b1, 16'd1);
    unit_row(8'h5C, 16'h002F, 16'd0, 1'b1, 1'b0);
    // two-byte backslash is not converted
    byte_row(8'hC1); byte_row(8'h9C);
    byte_row(8'hF8); byte_row(8'h88); byte_row(8'h80); byte_row(8'h80); byte_row(8'h81);
    unit_row(8'hFE, 16'h0000, 16'd3, 1'b0, 1'b1);
    unit_row(8'hFF, 16'h0000, 16'd0, 1'b1, 1'b1);
    unit_row(8'h00, 16'h0000, 16'd0, 1'b1, 1'b1);

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_regs(dir_rows[i].slash, dir_rows[i].cap);
      end else begin
        send_byte(dir_rows[i].b, i);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 45; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      if (ph == 0) write_regs(1'b0, 16'd0);
      else if (ph == 1) write_regs(1'b1, 16'hFFFF);
      else if ($urandom_range(0, 3) == 0)
        write_regs(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
      else write_regs(1'($urandom_range(0, 1)), 16'($urandom_range(0, 24)));
      start = sent_bytes;
      held  = 1'b0;
      while (sent_bytes - start < PHASE_BYTES) begin
        if (ph == 0 && !held && sent_bytes - start >= 40) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        send_char();
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
